// ----- rtl/ccv_pkg.sv -----
`default_nettype none
package ccv_pkg;

	localparam int SUM_W  = 64;
	localparam int ROOT_W = SUM_W / 2;

	localparam logic [2:0] REG_START_X = 3'd0;
	localparam logic [2:0] REG_START_Y = 3'd1;
	localparam logic [2:0] REG_START_Z = 3'd2;
	localparam logic [2:0] REG_END_X   = 3'd3;
	localparam logic [2:0] REG_END_Y   = 3'd4;
	localparam logic [2:0] REG_END_Z   = 3'd5;
	localparam logic [2:0] REG_LEAD    = 3'd6;
	localparam logic [2:0] REG_SPEED   = 3'd7;

endpackage
`default_nettype wire

// ----- rtl/ccv_delay.sv -----
`default_nettype none
module ccv_delay #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [WIDTH-1:0] d,
	output logic      [WIDTH-1:0] q
);

	logic [WIDTH-1:0] pipe_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_q[0] <= d;
			for (int k = 1; k < DEPTH; k++) begin
				pipe_q[k] <= pipe_q[k-1];
			end
		end
	end

	assign q = pipe_q[DEPTH-1];

endmodule
`default_nettype wire

// ----- rtl/ccv_isqrt.sv -----
`default_nettype none
module ccv_isqrt #(
	parameter int IW = ccv_pkg::SUM_W
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [IW-1:0]     rad,
	output logic      [IW/2-1:0]   root
);

	localparam int N = IW / 2;

	logic [IW-1:0] rem_q [N];
	logic [IW-1:0] acc_q [N];
	logic [IW-1:0] nin   [N];
	logic [IW-1:0] rin   [N];
	logic [IW-1:0] bitv  [N];
	logic [IW:0]   trial [N];
	logic          ge    [N];

	always_comb begin
		nin[0] = rad;
		rin[0] = '0;
		for (int k = 1; k < N; k++) begin
			nin[k] = rem_q[k-1];
			rin[k] = acc_q[k-1];
		end
		for (int k = 0; k < N; k++) begin
			bitv[k]  = IW'(1) << (IW - 2 - 2 * k);
			trial[k] = {1'b0, rin[k]} + {1'b0, bitv[k]};
			ge[k]    = ({1'b0, nin[k]} >= trial[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N; k++) begin
				if (ge[k]) begin
					rem_q[k] <= nin[k] - trial[k][IW-1:0];
					acc_q[k] <= (rin[k] >> 1) + bitv[k];
				end else begin
					rem_q[k] <= nin[k];
					acc_q[k] <= rin[k] >> 1;
				end
			end
		end
	end

	assign root = acc_q[N-1][N-1:0];

endmodule
`default_nettype wire

// ----- rtl/ccv_muldiv.sv -----
`default_nettype none
module ccv_muldiv #(
	parameter int DW = 32,
	parameter int QW = 31
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [DW-1:0] num_hi,
	input  wire logic [QW-1:0] num_lo,
	input  wire logic [DW-1:0] den,
	output logic      [QW-1:0] quo
);

	logic [DW-1:0] rem_q [QW];
	logic [DW-1:0] den_q [QW];
	logic [QW-1:0] lo_q  [QW];
	logic [QW-1:0] quo_q [QW];
	logic [DW-1:0] rin   [QW];
	logic [DW-1:0] din   [QW];
	logic [QW-1:0] loin  [QW];
	logic [QW-1:0] qin   [QW];
	logic [DW:0]   trial [QW];
	logic          ge    [QW];

	always_comb begin
		rin[0]  = num_hi;
		din[0]  = den;
		loin[0] = num_lo;
		qin[0]  = '0;
		for (int k = 1; k < QW; k++) begin
			rin[k]  = rem_q[k-1];
			din[k]  = den_q[k-1];
			loin[k] = lo_q[k-1];
			qin[k]  = quo_q[k-1];
		end
		for (int k = 0; k < QW; k++) begin
			trial[k] = {rin[k], loin[k][QW-1-k]};
			ge[k]    = (trial[k] >= {1'b0, din[k]});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QW; k++) begin
				rem_q[k] <= ge[k] ? DW'(trial[k] - {1'b0, din[k]}) : trial[k][DW-1:0];
				den_q[k] <= din[k];
				lo_q[k]  <= loin[k];
				quo_q[k] <= {qin[k][QW-2:0], ge[k]};
			end
		end
	end

	assign quo = quo_q[QW-1];

endmodule
`default_nettype wire

// ----- rtl/carrot_chase_velocity_3d_top.sv -----
// The longest path runs through two one-bit-a-stage square-root units and two
// one-bit-a-stage dividers in series.
// Throughput: one word per cycle; the whole pipeline holds while a finished
// word waits at the output.
// Reset clears the valid bits and all configuration registers to zero.
`default_nettype none
module carrot_chase_velocity_3d_top #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [2:0]             cfg_index,
	input  wire logic [COORD_WIDTH-1:0] cfg_data,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [COORD_WIDTH-1:0] pos_x,
	input  wire logic [COORD_WIDTH-1:0] pos_y,
	input  wire logic [COORD_WIDTH-1:0] pos_z,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [COORD_WIDTH-1:0]      vel_x,
	output logic [COORD_WIDTH-1:0]      vel_y,
	output logic [COORD_WIDTH-1:0]      vel_z
);

	localparam int W   = COORD_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int UW  = W - 1;
	localparam int PW  = 2 * W;
	localparam int NW  = 2 * W - 1;
	localparam int LTW = W + F + 1;
	localparam int SW  = ccv_pkg::SUM_W;
	localparam int RW  = ccv_pkg::ROOT_W;
	localparam int XW  = (PW + 2 > SW + 1) ? PW + 2 : SW + 1;
	localparam int MXW = (RW > UW) ? RW : UW;

	localparam int K_SQ  = 3 + RW;
	localparam int K_LP  = K_SQ + 1;
	localparam int LD    = K_LP + UW;
	localparam int K_T   = 4 + F;
	localparam int D_T2  = LD - K_T - 6;
	localparam int K_M   = LD + 3 + RW;
	localparam int K_OUT = K_M + W;

	localparam logic [W-1:0] CMAX = {1'b0, {UW{1'b1}}};
	localparam logic [W-1:0] CMIN = {1'b1, {UW{1'b0}}};
	localparam longint unsigned DEGEN_RAW =
		((64'd1 << (2 * F)) + 64'd500000) / 64'd1000000;
	localparam logic [SW-1:0] DEGEN_THR = (DEGEN_RAW == 0) ? SW'(1) : SW'(DEGEN_RAW);
	localparam logic [F:0] T_ONE = {1'b1, {F{1'b0}}};

	localparam logic [1:0] TSEL_ZERO = 2'd0;
	localparam logic [1:0] TSEL_ONE  = 2'd1;
	localparam logic [1:0] TSEL_DIV  = 2'd2;

	function automatic logic [W-1:0] sat1(input logic [W:0] x);
		if (x[W] != x[W-1]) return x[W] ? CMIN : CMAX;
		return x[W-1:0];
	endfunction

	function automatic logic [W-1:0] sat3(input logic [W+2:0] x);
		if (x[W+2:W-1] == {4{x[W+2]}}) return x[W-1:0];
		return x[W+2] ? CMIN : CMAX;
	endfunction

	function automatic logic [W-1:0] sub_sat(input logic [W-1:0] a, input logic [W-1:0] b);
		logic [W:0] d;
		d = {a[W-1], a} - {b[W-1], b};
		return sat1(d);
	endfunction

	function automatic logic [W-1:0] magn(input logic [W-1:0] x);
		return x[W-1] ? (~x + W'(1)) : x;
	endfunction

	function automatic logic [SW-1:0] sat_sum(input logic [XW-1:0] x);
		if (x[XW-1:SW] != '0) return '1;
		return x[SW-1:0];
	endfunction

	function automatic logic [SW-1:0] sum3(input logic [PW-1:0] a, input logic [PW-1:0] b,
			input logic [PW-1:0] c);
		return sat_sum(XW'(a) + XW'(b) + XW'(c));
	endfunction

	logic en;
	logic [K_OUT-1:0] vld_q;

	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;
	assign out_valid = vld_q[K_OUT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[K_OUT-2:0], in_valid};
		end
	end

	logic [2:0][W-1:0] start_q, end_q;
	logic [UW-1:0]     lead_q, speed_q;
	logic [SW-1:0]     lead2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			end_q   <= '0;
			lead_q  <= '0;
			speed_q <= '0;
			lead2_q <= '0;
		end else begin
			lead2_q <= sat_sum(XW'(lead_q) * XW'(lead_q));
			if (cfg_we) begin
				unique case (cfg_index)
					ccv_pkg::REG_START_X: start_q[0] <= cfg_data;
					ccv_pkg::REG_START_Y: start_q[1] <= cfg_data;
					ccv_pkg::REG_START_Z: start_q[2] <= cfg_data;
					ccv_pkg::REG_END_X:   end_q[0]   <= cfg_data;
					ccv_pkg::REG_END_Y:   end_q[1]   <= cfg_data;
					ccv_pkg::REG_END_Z:   end_q[2]   <= cfg_data;
					ccv_pkg::REG_LEAD:    lead_q     <= cfg_data[UW-1:0];
					ccv_pkg::REG_SPEED:   speed_q    <= cfg_data[UW-1:0];
				endcase
			end
		end
	end

	logic [2:0][W-1:0] pos_v;
	assign pos_v = {pos_z, pos_y, pos_x};

	// front: differences, squares, sums
	logic [2:0][W-1:0]  p_s1, g_s1, d_s1, l_s1;
	logic [2:0][W-1:0]  p_s2, g_s2, l_s2;
	logic [2:0][PW-1:0] gsq_s2, lsq_s2, dl_s2;
	logic [2:0]         dln_s2;
	logic [2:0][W-1:0]  p_s3, g_s3, l_s3;
	logic [SW-1:0]      gsum_s3, lensq_s3, pos_s3, neg_s3;
	logic               degen_s3;
	logic [SW-1:0]      lensq_c;
	logic [2:0][W-1:0]  p_s4, g_s4, l_s4;
	logic [SW-1:0]      diff_s4, lensq_s4;
	logic [1:0]         tsel_s4;
	logic               degen_s4;

	assign lensq_c = sum3(lsq_s2[0], lsq_s2[1], lsq_s2[2]);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				p_s1[i] <= pos_v[i];
				g_s1[i] <= sub_sat(end_q[i], pos_v[i]);
				d_s1[i] <= sub_sat(pos_v[i], start_q[i]);
				l_s1[i] <= sub_sat(end_q[i], start_q[i]);

				gsq_s2[i] <= PW'(magn(g_s1[i])) * PW'(magn(g_s1[i]));
				lsq_s2[i] <= PW'(magn(l_s1[i])) * PW'(magn(l_s1[i]));
				dl_s2[i]  <= PW'(magn(d_s1[i])) * PW'(magn(l_s1[i]));
				dln_s2[i] <= d_s1[i][W-1] ^ l_s1[i][W-1];
			end
			p_s2 <= p_s1;
			g_s2 <= g_s1;
			l_s2 <= l_s1;

			gsum_s3  <= sum3(gsq_s2[0], gsq_s2[1], gsq_s2[2]);
			lensq_s3 <= lensq_c;
			degen_s3 <= (lensq_c < DEGEN_THR);
			pos_s3   <= sum3(dln_s2[0] ? '0 : dl_s2[0], dln_s2[1] ? '0 : dl_s2[1],
				dln_s2[2] ? '0 : dl_s2[2]);
			neg_s3   <= sum3(dln_s2[0] ? dl_s2[0] : '0, dln_s2[1] ? dl_s2[1] : '0,
				dln_s2[2] ? dl_s2[2] : '0);
			p_s3 <= p_s2;
			g_s3 <= g_s2;
			l_s3 <= l_s2;

			if (neg_s3 >= pos_s3) begin
				tsel_s4 <= TSEL_ZERO;
			end else if (pos_s3 - neg_s3 >= lensq_s3) begin
				tsel_s4 <= TSEL_ONE;
			end else begin
				tsel_s4 <= TSEL_DIV;
			end
			diff_s4  <= pos_s3 - neg_s3;
			lensq_s4 <= lensq_s3;
			degen_s4 <= degen_s3;
			p_s4 <= p_s3;
			g_s4 <= g_s3;
			l_s4 <= l_s3;
		end
	end

	// projection parameter
	logic [F-1:0]      tq;
	logic [1:0]        tsel_k;
	logic              degen_k;
	logic [2:0][W-1:0] p_k, g_k, l_k;

	ccv_muldiv #(.DW(SW), .QW(F)) u_tdiv (
		.clk(clk), .en(en), .num_hi(diff_s4), .num_lo('0), .den(lensq_s4), .quo(tq)
	);

	ccv_delay #(.WIDTH(3 + 9 * W), .DEPTH(F)) u_tdly (
		.clk(clk), .en(en),
		.d({tsel_s4, degen_s4, p_s4, g_s4, l_s4}),
		.q({tsel_k, degen_k, p_k, g_k, l_k})
	);

	logic [F:0]            t_s5;
	logic [2:0][W-1:0]     p_s5, g_s5, l_s5;
	logic                  degen_s5;
	logic [2:0][LTW-1:0]   lt_s6;
	logic [2:0]            lneg_s6, lneg_s7, lneg_s8, lneg_s9, lneg_s10;
	logic [2:0][W-1:0]     p_s6, g_s6, p_s7, g_s7, p_s8, g_s8, p_s9, g_s9, p_s10, g_s10;
	logic                  degen_s6, degen_s7, degen_s8, degen_s9, degen_s10;
	logic [2:0][W+1:0]     proj_s7, proj_s8, proj_s9, proj_s10;
	logic [2:0][W-1:0]     w_s8;
	logic [2:0][PW-1:0]    wsq_s9;
	logic                  far_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			unique case (tsel_k)
				TSEL_ZERO: t_s5 <= '0;
				TSEL_ONE:  t_s5 <= T_ONE;
				default:   t_s5 <= {1'b0, tq};
			endcase
			p_s5 <= p_k;
			g_s5 <= g_k;
			l_s5 <= l_k;
			degen_s5 <= degen_k;

			for (int i = 0; i < 3; i++) begin
				lt_s6[i]   <= LTW'(magn(l_s5[i])) * LTW'(t_s5);
				lneg_s6[i] <= l_s5[i][W-1];
				proj_s7[i] <= {{2{start_q[i][W-1]}}, start_q[i]}
					+ (lneg_s6[i] ? -(W+2)'(lt_s6[i][F+W:F]) : (W+2)'(lt_s6[i][F+W:F]));
				w_s8[i]    <= sat3({{3{end_q[i][W-1]}}, end_q[i]}
					- {proj_s7[i][W+1], proj_s7[i]});
				wsq_s9[i]  <= PW'(magn(w_s8[i])) * PW'(magn(w_s8[i]));
			end
			p_s6 <= p_s5;   g_s6 <= g_s5;   degen_s6 <= degen_s5;
			p_s7 <= p_s6;   g_s7 <= g_s6;   degen_s7 <= degen_s6;   lneg_s7 <= lneg_s6;
			p_s8 <= p_s7;   g_s8 <= g_s7;   degen_s8 <= degen_s7;   lneg_s8 <= lneg_s7;
			p_s9 <= p_s8;   g_s9 <= g_s8;   degen_s9 <= degen_s8;   lneg_s9 <= lneg_s8;
			p_s10 <= p_s9;  g_s10 <= g_s9;  degen_s10 <= degen_s9;  lneg_s10 <= lneg_s9;
			proj_s8  <= proj_s7;
			proj_s9  <= proj_s8;
			proj_s10 <= proj_s9;
			far_s10  <= !(sum3(wsq_s9[0], wsq_s9[1], wsq_s9[2]) < lead2_q);
		end
	end

	logic              far_d, degen_d;
	logic [2:0]        lneg_d;
	logic [2:0][W+1:0] proj_d;
	logic [2:0][W-1:0] p_d, g_d;

	ccv_delay #(.WIDTH(5 + 3 * (W + 2) + 6 * W), .DEPTH(D_T2)) u_pdly (
		.clk(clk), .en(en),
		.d({far_s10, degen_s10, lneg_s10, proj_s10, p_s10, g_s10}),
		.q({far_d, degen_d, lneg_d, proj_d, p_d, g_d})
	);

	// lead offset along the segment
	logic [RW-1:0]     len_l, dist_e, dist_d;
	logic [2:0][W-1:0] lmag_c, lmag_d;
	logic [2:0][NW-1:0] nl_s11;
	logic [RW-1:0]     len_s11;
	logic [2:0][UW-1:0] lq;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			lmag_c[i] = magn(l_s3[i]);
		end
	end

	ccv_isqrt #(.IW(SW)) u_sqrt_len (.clk(clk), .en(en), .rad(lensq_s3), .root(len_l));
	ccv_isqrt #(.IW(SW)) u_sqrt_dist (.clk(clk), .en(en), .rad(gsum_s3), .root(dist_e));

	ccv_delay #(.WIDTH(3 * W), .DEPTH(RW)) u_ldly (
		.clk(clk), .en(en), .d(lmag_c), .q(lmag_d)
	);

	ccv_delay #(.WIDTH(RW), .DEPTH(W)) u_ddly (
		.clk(clk), .en(en), .d(dist_e), .q(dist_d)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				nl_s11[i] <= NW'(lmag_d[i]) * NW'(lead_q);
			end
			len_s11 <= len_l;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_lead
		ccv_muldiv #(.DW(RW), .QW(UW)) u_ldiv (
			.clk(clk), .en(en),
			.num_hi(RW'(nl_s11[i] >> UW)), .num_lo(nl_s11[i][UW-1:0]),
			.den(len_s11), .quo(lq[i])
		);
	end

	// aim vector and final scaling
	logic [2:0][W-1:0]  aim_s12;
	logic [UW-1:0]      speed_s12;
	logic [2:0][PW-1:0] asq_s13;
	logic [2:0][NW-1:0] an_s13, an_s14;
	logic [2:0]         aneg_s13, aneg_s14;
	logic [SW-1:0]      asum_s14;
	logic [2:0][W-1:0]  s_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			s_c[i] = lneg_d[i] ? -W'(lq[i]) : W'(lq[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				aim_s12[i] <= (!degen_d && far_d)
					? sat3({proj_d[i][W+1], proj_d[i]} + {{3{s_c[i][W-1]}}, s_c[i]}
						- {{3{p_d[i][W-1]}}, p_d[i]})
					: g_d[i];
				asq_s13[i]  <= PW'(magn(aim_s12[i])) * PW'(magn(aim_s12[i]));
				an_s13[i]   <= NW'(magn(aim_s12[i])) * NW'(speed_s12);
				aneg_s13[i] <= aim_s12[i][W-1];
			end
			speed_s12 <= (MXW'(dist_d) < MXW'(speed_q)) ? UW'(dist_d) : speed_q;
			asum_s14  <= sum3(asq_s13[0], asq_s13[1], asq_s13[2]);
			an_s14    <= an_s13;
			aneg_s14  <= aneg_s13;
		end
	end

	logic [RW-1:0]      mag_m;
	logic [2:0][NW-1:0] an_m;
	logic [2:0]         aneg_m, aneg_z;
	logic               zero_z;
	logic [2:0][UW-1:0] vq;

	ccv_isqrt #(.IW(SW)) u_sqrt_aim (.clk(clk), .en(en), .rad(asum_s14), .root(mag_m));

	ccv_delay #(.WIDTH(3 + 3 * NW), .DEPTH(RW)) u_adly (
		.clk(clk), .en(en), .d({aneg_s14, an_s14}), .q({aneg_m, an_m})
	);

	for (genvar i = 0; i < 3; i++) begin : g_vel
		ccv_muldiv #(.DW(RW), .QW(UW)) u_vdiv (
			.clk(clk), .en(en),
			.num_hi(RW'(an_m[i] >> UW)), .num_lo(an_m[i][UW-1:0]),
			.den(mag_m), .quo(vq[i])
		);
	end

	ccv_delay #(.WIDTH(4), .DEPTH(UW)) u_zdly (
		.clk(clk), .en(en), .d({aneg_m, (mag_m == '0)}), .q({aneg_z, zero_z})
	);

	logic [2:0][W-1:0] vel_s15;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				vel_s15[i] <= zero_z ? '0 : (aneg_z[i] ? -W'(vq[i]) : W'(vq[i]));
			end
		end
	end

	assign vel_x = vel_s15[0];
	assign vel_y = vel_s15[1];
	assign vel_z = vel_s15[2];

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("valid chain moved during a hold");

	a_t_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[K_T] |-> (t_s5 <= T_ONE))
		else $error("projection parameter above one");

	a_speed_cap: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[LD] |-> (speed_s12 <= speed_q))
		else $error("speed above limit");

endmodule
`default_nettype wire

// ----- tb/carrot_chase_velocity_3d_top_tb.sv -----
`default_nettype none
module carrot_chase_velocity_3d_top_tb;

	localparam int          CW          = 32;
	localparam int          FB          = 16;
	localparam int          SETTLE      = 2 * 32 + 2 * CW + 6 + 10;
	localparam int          STALL_LIMIT = 20000;
	localparam longint      CMAX        = 64'sh7fffffff;
	localparam longint      CMIN        = -64'sh80000000;
	localparam bit [63:0]   DEGEN_SQ    = ((64'd1 << (2 * FB)) + 64'd500000) / 64'd1000000;
	localparam bit [63:0]   ONE         = 64'd1 << FB;

	typedef struct packed {
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic [CW-1:0] z;
	} vel_t;

	logic          clk = 0;
	logic          arst_n = 0;
	logic          cfg_we = 0;
	logic [2:0]    cfg_index = '0;
	logic [CW-1:0] cfg_data = '0;
	logic          in_valid = 0;
	logic          in_stall;
	logic [CW-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic          out_valid;
	logic          out_stall = 0;
	logic [CW-1:0] vel_x, vel_y, vel_z;

	carrot_chase_velocity_3d_top #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) DUT (.*);

	always #1 clk = ~clk;

	longint    seg_start[3];
	longint    seg_end[3];
	bit [63:0] lead_dist;
	bit [63:0] speed_cap;

	vel_t expected_vel[$];
	int   mismatches = 0;
	int   words_in = 0, words_out = 0;
	int   send_idle_pct = 0, recv_idle_pct = 0;
	int   hold_off = 0;
	int   idle_count = 0;

	function automatic longint sat_coord(longint v);
		if (v > CMAX) return CMAX;
		if (v < CMIN) return CMIN;
		return v;
	endfunction

	function automatic bit [63:0] magn(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic bit [63:0] mul_sat(bit [63:0] a, bit [63:0] b);
		bit [127:0] p;
		p = 128'(a) * 128'(b);
		return p[127:64] != 0 ? '1 : p[63:0];
	endfunction

	function automatic bit [63:0] add_sat(bit [63:0] a, bit [63:0] b);
		bit [64:0] s;
		s = 65'(a) + 65'(b);
		return s[64] ? '1 : s[63:0];
	endfunction

	function automatic bit [63:0] norm_sq(longint v[3]);
		bit [63:0] s;
		s = 0;
		for (int i = 0; i < 3; i++)
			s = add_sat(s, mul_sat(magn(v[i]), magn(v[i])));
		return s;
	endfunction

	function automatic bit [63:0] floor_sqrt(bit [63:0] n);
		bit [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic bit [63:0] mul_div(bit [63:0] a, bit [63:0] b, bit [63:0] c);
		bit [127:0] q;
		q = (128'(a) * 128'(b)) / 128'(c);
		return q[127:64] != 0 ? '1 : q[63:0];
	endfunction

	function automatic longint scale_by(longint v, bit [63:0] num, bit [63:0] den);
		bit [63:0] m;
		m = mul_div(magn(v), num, den);
		if (v < 0) return m > 64'(CMAX) ? CMIN : -longint'(m);
		return m > 64'(CMAX) ? CMAX : longint'(m);
	endfunction

	function automatic vel_t chase_velocity(logic [CW-1:0] px, logic [CW-1:0] py,
			logic [CW-1:0] pz);
		longint    p[3], g[3], l[3], d[3], proj[3], w[3], aim[3], v[3];
		bit [63:0] dist_end, speed, lensq, mag, pos_s, neg_s, t, pr, len_l;
		vel_t      r;
		p[0] = longint'($signed(px));
		p[1] = longint'($signed(py));
		p[2] = longint'($signed(pz));
		for (int i = 0; i < 3; i++) begin
			g[i] = sat_coord(seg_end[i] - p[i]);
			l[i] = sat_coord(seg_end[i] - seg_start[i]);
			d[i] = sat_coord(p[i] - seg_start[i]);
			aim[i] = g[i];
		end
		dist_end = floor_sqrt(norm_sq(g));
		speed = dist_end < speed_cap ? dist_end : speed_cap;
		lensq = norm_sq(l);
		if (lensq >= (DEGEN_SQ == 0 ? 64'd1 : DEGEN_SQ)) begin
			pos_s = 0;
			neg_s = 0;
			for (int i = 0; i < 3; i++) begin
				pr = mul_sat(magn(d[i]), magn(l[i]));
				if ((d[i] < 0) != (l[i] < 0)) neg_s = add_sat(neg_s, pr);
				else pos_s = add_sat(pos_s, pr);
			end
			if (neg_s >= pos_s) t = 0;
			else if (pos_s - neg_s >= lensq) t = ONE;
			else t = mul_div(pos_s - neg_s, ONE, lensq);
			for (int i = 0; i < 3; i++) begin
				proj[i] = seg_start[i] + scale_by(l[i], t, ONE);
				w[i] = sat_coord(seg_end[i] - proj[i]);
			end
			if (!(norm_sq(w) < mul_sat(lead_dist, lead_dist))) begin
				len_l = floor_sqrt(lensq);
				for (int i = 0; i < 3; i++)
					aim[i] = sat_coord(proj[i] + scale_by(l[i], lead_dist, len_l) - p[i]);
			end
		end
		mag = floor_sqrt(norm_sq(aim));
		for (int i = 0; i < 3; i++)
			v[i] = mag == 0 ? 0 : scale_by(aim[i], speed, mag);
		r.x = v[0][CW-1:0];
		r.y = v[1][CW-1:0];
		r.z = v[2][CW-1:0];
		return r;
	endfunction

	// receive side: check, then choose stall for the next cycle
	always @(posedge clk) begin
		vel_t want;
		if (out_valid && !out_stall) begin
			words_out++;
			if (expected_vel.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: vel %h %h %h", vel_x, vel_y, vel_z);
			end else begin
				want = expected_vel.pop_front();
				if (want.x !== vel_x || want.y !== vel_y || want.z !== vel_z) begin
					mismatches++;
					if (mismatches <= 10)
						$display("word %0d: expected %h %h %h, got %h %h %h", words_out,
							want.x, want.y, want.z, vel_x, vel_y, vel_z);
				end
			end
		end
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_stall <= 1;
		end else begin
			out_stall <= $urandom_range(99) < recv_idle_pct;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_count <= 0;
		end else if (idle_count >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_count <= idle_count + 1;
		end
	end

	task automatic send_pos(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		pos_x <= x;
		pos_y <= y;
		pos_z <= z;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_vel.push_back(chase_velocity(x, y, z));
		words_in++;
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (expected_vel.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic load_cfg(logic [CW-1:0] sx, logic [CW-1:0] sy, logic [CW-1:0] sz,
			logic [CW-1:0] ex, logic [CW-1:0] ey, logic [CW-1:0] ez,
			logic [CW-1:0] lead, logic [CW-1:0] spd);
		logic [CW-1:0] vals[8];
		vals = '{sx, sy, sz, ex, ey, ez, lead, spd};
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1;
			cfg_index <= 3'(i);
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 0;
		for (int i = 0; i < 3; i++) begin
			seg_start[i] = longint'($signed(vals[ccv_pkg::REG_START_X + i]));
			seg_end[i] = longint'($signed(vals[ccv_pkg::REG_END_X + i]));
		end
		lead_dist = 64'(lead[CW-2:0]);
		speed_cap = 64'(spd[CW-2:0]);
		@(posedge clk);
	endtask

	function automatic logic [CW-1:0] rand_coord(bit near);
		if (near) return CW'($signed($urandom_range(32'h01ff_ffff)) - 32'sh0100_0000);
		return $urandom;
	endfunction

	function automatic logic [CW-1:0] rand_dist();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 0;
			default: return $urandom_range(32'h000f_ffff);
		endcase
	endfunction

	task automatic random_cfg();
		logic [CW-1:0] s[3], e[3];
		bit near;
		near = $urandom_range(4) != 0;
		for (int i = 0; i < 3; i++) begin
			s[i] = rand_coord(near);
			e[i] = rand_coord(near);
		end
		if ($urandom_range(7) == 0)
			for (int i = 0; i < 3; i++) e[i] = s[i] + $urandom_range(15) - 8;
		load_cfg(s[0], s[1], s[2], e[0], e[1], e[2], rand_dist(), rand_dist());
	endtask

	task automatic random_words(int n);
		for (int k = 0; k < n; k++)
			send_pos(rand_coord($urandom_range(3) != 0), rand_coord($urandom_range(3) != 0),
				rand_coord($urandom_range(3) != 0));
	endtask

	task automatic test_directed();
		// segment along X, 10 m, lead 1 m, speed 2 m/s
		load_cfg(0, 0, 0, 32'h000a_0000, 0, 0, 32'h0001_0000, 32'h0002_0000);
		send_pos(0, 0, 0);
		send_pos(32'h0005_0000, 32'h0003_0000, 32'hfffd_0000);
		send_pos(32'h0009_8000, 0, 0);
		send_pos(32'h000a_0000, 0, 0);
		send_pos(32'hfff0_0000, 32'h0001_0000, 0);
		send_pos(32'h0014_0000, 0, 32'h0001_0000);
		send_pos(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send_pos(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_pos(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
		drain();
		// degenerate segment, unused top bits of lead and speed set
		load_cfg(32'h0003_0000, 32'h0001_0000, 0, 32'h0003_0001, 32'h0001_0000, 0,
			32'hffff_ffff, 32'h8000_4000);
		send_pos(0, 0, 0);
		send_pos(32'h0003_0001, 32'h0001_0000, 0);
		send_pos(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
		drain();
		// widest segment, largest lead and speed
		load_cfg(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send_pos(0, 0, 0);
		send_pos(32'h8000_0000, 32'h7fff_ffff, 0);
		send_pos(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send_pos(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		drain();
		// zero speed, zero lead
		load_cfg(32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0, 0, 0);
		send_pos(32'h1234_5678, 32'hedcb_a987, 32'h0000_ffff);
		send_pos(0, 32'h0001_0000, 0);
		drain();
	endtask

	task automatic test_random(int sidle, int ridle, int sets, int per_set);
		send_idle_pct = sidle;
		recv_idle_pct = ridle;
		for (int k = 0; k < sets; k++) begin
			random_cfg();
			random_words(per_set);
			drain();
		end
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_cfg();
		hold_off = 400;
		random_words(300);
		drain();
		random_words(50);
		drain();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_random(9, 70, 6, 80);
		test_random(70, 9, 6, 80);
		test_random(0, 0, 6, 80);
		test_backpressure();
		$display("Covered directed extremes, degenerate and zero cases, %0d words in, %0d out",
			words_in, words_out);
		$display("under random configurations, idling on both sides and a long output hold-off");
		if (mismatches == 0 && expected_vel.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches, %0d words missing", mismatches, expected_vel.size());
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire
